// ===== rtl/core/lnc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lnc_pkg: shared types and constants
// Widths, tap count, register indexes and sequencer states for the canceller.
// ----------------------------------------------------------------------------
package lnc_pkg;

  localparam int Taps     = 32;
  localparam int TapW     = $clog2(Taps);
  localparam int TapCntW  = TapW + 1;
  localparam int DivSteps = 46;
  localparam int DivCntW  = $clog2(DivSteps + 1);

  localparam logic [2:0] RegStep    = 3'd0;
  localparam logic [2:0] RegLeak    = 3'd1;
  localparam logic [2:0] RegFloor   = 3'd2;
  localparam logic [2:0] RegEnable  = 3'd3;
  localparam logic [2:0] RegDistrac = 3'd4;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SHIFT = 7'b0000010,
    ST_DOT   = 7'b0000100,
    ST_ERR   = 7'b0001000,
    ST_DIV   = 7'b0010000,
    ST_UPD   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

endpackage : lnc_pkg
`default_nettype wire

// ===== rtl/core/lnc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lnc_ram: generic simple dual-port RAM
// One write and one read per cycle on separate addresses, registered read data.
// ----------------------------------------------------------------------------
module lnc_ram #(
  parameter int Width = 16,
  parameter int Depth = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem_r [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/core/lnc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lnc_div: restoring divider
// Unsigned 56-bit by 42-bit division with a quotient that fits in 46 bits,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lnc_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [55:0] dividend,
  input  wire logic [41:0] divisor,
  output logic             busy,
  output logic      [45:0] quotient
);
  logic [45:0] quo_r, quo_nxt;
  logic [42:0] rem_r, rem_nxt;
  logic [41:0] dvs_r, dvs_nxt;
  logic [lnc_pkg::DivCntW-1:0] cnt_r, cnt_nxt;
  logic [43:0] trial;

  // The divisor is at least 1024, so the top ten dividend bits are below it
  // and can be preloaded as the starting remainder.
  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    trial   = {rem_r, quo_r[45]} - {2'b00, dvs_r};
    if (start) begin
      quo_nxt = dividend[45:0];
      rem_nxt = {33'd0, dividend[55:46]};
      dvs_nxt = divisor;
      cnt_nxt = lnc_pkg::DivCntW'(lnc_pkg::DivSteps);
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      if (!trial[43]) begin
        rem_nxt = trial[42:0];
        quo_nxt = {quo_r[44:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[41:0], quo_r[45]};
        quo_nxt = {quo_r[44:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = (cnt_r != '0);
  assign quotient = quo_r;
endmodule
`default_nettype wire

// ===== rtl/core/leaky_nlms_canceller.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// leaky_nlms_canceller: leaky NLMS adaptive noise canceller
// Cancels a reference-correlated interference from a focus signal.
// ----------------------------------------------------------------------------
// Usage: present a focus and reference word pair on the input channel
// (in_valid/in_stall). The block stalls its input while it works on a word.
// Each word runs a sequencer around a shared multiplier: a write of the
// new reference into the history memory, a pass over the taps for the dot
// product and energy, a step for the error and floor, a bit-serial gain
// division (only when adapting), a pass over the taps for the weight
// update, and an output step. The cleaned word is held in an output
// register until the receiver drops out_stall; the next input word is not
// taken before then. Reset sets control and config registers to defaults
// and sweeps history and weight memories to zero, with in_stall held
// high. Configuration should be written only while no word is in flight.
// ----------------------------------------------------------------------------
module leaky_nlms_canceller (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic signed [15:0] in_focus_sample,
  input  wire logic signed [15:0] in_reference_sample,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [15:0] out_cleaned_sample
);
  localparam int TW = lnc_pkg::TapW;
  localparam int CW = lnc_pkg::TapCntW;

  // Configuration registers.
  logic [15:0] step_r;
  logic [12:0] leak_r;
  logic [15:0] floor_r;
  logic        en_r, dis_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= 16'd32768;
      leak_r  <= '0;
      floor_r <= 16'd32768;
      en_r    <= 1'b0;
      dis_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lnc_pkg::RegStep:    step_r  <= cfg_data;
        lnc_pkg::RegLeak:    leak_r  <= cfg_data[12:0];
        lnc_pkg::RegFloor:   floor_r <= cfg_data;
        lnc_pkg::RegEnable:  en_r    <= cfg_data[0];
        lnc_pkg::RegDistrac: dis_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The history is a circular buffer: head_r points at the newest entry.
  lnc_pkg::state_t st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [TW-1:0] head_r, head_nxt;
  logic          clr_r, clr_nxt;
  logic [TW-1:0] clr_cnt_r, clr_cnt_nxt;

  logic signed [15:0] focus_r, focus_nxt;
  logic signed [63:0] acc_r, acc_nxt;
  logic [41:0]        norm_r, norm_nxt;
  logic signed [15:0] y_r, y_nxt;
  logic               adapt_r, adapt_nxt;
  logic               gneg_r, gneg_nxt;
  logic signed [47:0] g_r, g_nxt;
  logic signed [15:0] outd_r, outd_nxt;
  logic               ov_r, ov_nxt;

  // Memories: one write and one read address each.
  logic          h_we, w_we;
  logic [TW-1:0] h_waddr, h_raddr, w_waddr, w_raddr;
  logic [15:0]   h_wdata, h_rdata;
  logic [31:0]   w_wdata, w_rdata;

  lnc_ram #(.Width(16), .Depth(lnc_pkg::Taps)) u_hist (
    .clk, .we(h_we), .waddr(h_waddr), .wdata(h_wdata), .raddr(h_raddr),
    .rdata(h_rdata)
  );
  lnc_ram #(.Width(32), .Depth(lnc_pkg::Taps)) u_wts (
    .clk, .we(w_we), .waddr(w_waddr), .wdata(w_wdata), .raddr(w_raddr),
    .rdata(w_rdata)
  );

  // History word read back, and its square for the energy sum.
  logic signed [15:0] h_s;
  logic signed [31:0] h_sq;
  assign h_s  = h_rdata;
  assign h_sq = h_s * h_s;

  // Divider.
  logic        div_start;
  logic        div_busy;
  logic [45:0] quot;
  logic [55:0] div_num;
  lnc_div u_div (
    .clk, .rst_n, .start(div_start), .dividend(div_num),
    .divisor(norm_r), .busy(div_busy), .quotient(quot)
  );

  // Shared multiplier, 32 x 17 signed; operands chosen by state.
  logic signed [31:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [48:0] mul_p;
  assign mul_p = mul_a * mul_b;

  // Error path combinational terms. The estimate can reach about 2^27, so
  // the error is carried at 32 bits until it is saturated.
  logic signed [63:0] est_t;
  logic signed [31:0] err_t, ea_t, ea_fl;
  logic [31:0]        min_abs;
  logic [15:0]        fa;
  logic signed [31:0] errf;
  logic [31:0]        num_mag;

  // Update path: weight read at tap cnt-1 arrives, product cycles.
  logic signed [31:0] wq_r, wq_nxt;
  logic signed [47:0] leak_p;
  logic signed [63:0] gain_p;
  logic signed [63:0] nw;
  logic signed [31:0] nw_sat;
  logic signed [15:0] hq_r, hq_nxt;
  logic [TW-1:0]      wb_addr_r, wb_addr_nxt;
  logic               wb_r, wb_nxt;
  logic signed [63:0] gh_p;

  always_comb begin
    st_nxt      = st_r;
    cnt_nxt     = cnt_r;
    head_nxt    = head_r;
    clr_nxt     = clr_r;
    clr_cnt_nxt = clr_cnt_r;
    focus_nxt   = focus_r;
    acc_nxt     = acc_r;
    norm_nxt    = norm_r;
    y_nxt       = y_r;
    adapt_nxt   = adapt_r;
    gneg_nxt    = gneg_r;
    g_nxt       = g_r;
    outd_nxt    = outd_r;
    ov_nxt      = ov_r;
    wq_nxt      = wq_r;
    hq_nxt      = hq_r;
    wb_addr_nxt = wb_addr_r;
    wb_nxt      = 1'b0;
    h_we        = 1'b0;
    w_we        = 1'b0;
    h_raddr     = head_r + cnt_r[TW-1:0];
    h_waddr     = head_r;
    w_raddr     = cnt_r[TW-1:0];
    w_waddr     = wb_addr_r;
    h_wdata     = in_reference_sample;
    w_wdata     = '0;
    div_start   = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    est_t = '0; err_t = '0; ea_t = '0; ea_fl = '0; min_abs = '0; fa = '0;
    errf = '0; num_mag = '0; leak_p = '0; gain_p = '0; nw = '0;
    nw_sat = '0; gh_p = '0;
    div_num = '0;

    if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end

    if (clr_r) begin
      h_we = 1'b1; w_we = 1'b1;
      h_waddr = clr_cnt_r; w_waddr = clr_cnt_r;
      h_wdata = '0; w_wdata = '0;
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (clr_cnt_r == TW'(lnc_pkg::Taps - 1)) begin
        clr_nxt = 1'b0;
      end
    end else begin
      unique case (st_r)
        lnc_pkg::ST_IDLE: begin
          if (in_valid && !ov_r) begin
            head_nxt  = head_r - 1'b1;
            focus_nxt = in_focus_sample;
            st_nxt    = lnc_pkg::ST_SHIFT;
          end
        end
        lnc_pkg::ST_SHIFT: begin
          h_we    = 1'b1;
          h_waddr = head_r;
          h_wdata = hq_r;
          acc_nxt = '0;
          norm_nxt = 42'd1024;
          cnt_nxt = '0;
          st_nxt  = lnc_pkg::ST_DOT;
        end
        lnc_pkg::ST_DOT: begin
          // Read tap cnt; accumulate tap cnt-1 (data of previous read).
          if (cnt_r != '0) begin
            mul_a   = $signed(w_rdata);
            mul_b   = 17'(h_s);
            acc_nxt = acc_r + 64'(mul_p);
            norm_nxt = norm_r + 42'($unsigned(h_sq));
          end
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == CW'(lnc_pkg::Taps)) begin
            st_nxt = lnc_pkg::ST_ERR;
          end
        end
        lnc_pkg::ST_ERR: begin
          est_t = (acc_r + 64'sd8388608) >>> 24;
          err_t = 32'(focus_r) - 32'(est_t);
          errf  = err_t;
          if (focus_r != '0) begin
            fa      = focus_r[15] ? 16'(-focus_r) : focus_r;
            mul_a   = 32'($signed({1'b0, floor_r}));
            mul_b   = 17'($signed({1'b0, fa}));
            min_abs = 32'((mul_p + 49'sd16384) >>> 15);
            ea_t    = err_t[31] ? -err_t : err_t;
            ea_fl   = ($unsigned(ea_t) < min_abs) ? $signed(min_abs) : ea_t;
            errf    = err_t[31] ? -ea_fl : ea_fl;
          end
          if (errf > 32'sd32767) begin
            y_nxt = 16'sh7fff;
          end else if (errf < -32'sd32768) begin
            y_nxt = 16'sh8000;
          end else begin
            y_nxt = errf[15:0];
          end
          adapt_nxt = en_r && dis_r;
          g_nxt     = '0;
          st_nxt    = (en_r && dis_r) ? lnc_pkg::ST_DIV : lnc_pkg::ST_UPD;
          cnt_nxt   = '0;
        end
        lnc_pkg::ST_DIV: begin
          mul_a   = 32'($signed({1'b0, step_r}));
          mul_b   = 17'(y_r);
          num_mag = mul_p[48] ? 32'(-mul_p) : 32'(mul_p);
          div_num = {num_mag, 24'd0};
          if (cnt_r == '0) begin
            div_start = 1'b1;
            gneg_nxt  = mul_p[48];
            cnt_nxt   = CW'(1);
          end else if (!div_busy) begin
            g_nxt   = gneg_r ? -$signed(48'(quot)) : $signed(48'(quot));
            cnt_nxt = '0;
            st_nxt  = lnc_pkg::ST_UPD;
          end
        end
        lnc_pkg::ST_UPD: begin
          // A tap is read, then its weight and history word are latched,
          // then both products are formed and the weight written back.
          if (cnt_r != '0 && cnt_r <= CW'(lnc_pkg::Taps)) begin
            wq_nxt      = $signed(w_rdata);
            hq_nxt      = h_s;
            wb_addr_nxt = TW'(cnt_r - 1'b1);
            wb_nxt      = 1'b1;
          end
          if (wb_r) begin
            leak_p = wq_r * $signed({1'b0, leak_r});
            gh_p   = g_r * hq_r;
            nw = 64'(wq_r) - ((64'(leak_p) + 64'sd32768) >>> 16);
            if (adapt_r && g_r != '0) begin
              nw = nw + ((gh_p + 64'sd16384) >>> 15);
            end
            if (nw > 64'sd2147483647) nw_sat = 32'sh7fffffff;
            else if (nw < -64'sd2147483648) nw_sat = 32'sh80000000;
            else nw_sat = 32'(nw);
            w_we    = 1'b1;
            w_waddr = wb_addr_r;
            w_wdata = nw_sat;
          end
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == CW'(lnc_pkg::Taps + 1)) begin
            st_nxt = lnc_pkg::ST_OUT;
          end
        end
        lnc_pkg::ST_OUT: begin
          outd_nxt = y_r;
          ov_nxt   = 1'b1;
          st_nxt   = lnc_pkg::ST_IDLE;
        end
        default: st_nxt = lnc_pkg::ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= lnc_pkg::ST_IDLE;
      cnt_r     <= '0;
      head_r    <= '0;
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
      ov_r      <= 1'b0;
      wb_r      <= 1'b0;
      adapt_r   <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      cnt_r     <= cnt_nxt;
      head_r    <= head_nxt;
      clr_r     <= clr_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      ov_r      <= ov_nxt;
      wb_r      <= wb_nxt;
      adapt_r   <= adapt_nxt;
    end
    focus_r   <= focus_nxt;
    acc_r     <= acc_nxt;
    norm_r    <= norm_nxt;
    y_r       <= y_nxt;
    gneg_r    <= gneg_nxt;
    g_r       <= g_nxt;
    outd_r    <= outd_nxt;
    wq_r      <= wq_nxt;
    hq_r      <= (st_r == lnc_pkg::ST_IDLE) ? in_reference_sample : hq_nxt;
    wb_addr_r <= wb_addr_nxt;
  end

  assign in_stall           = clr_r || (st_r != lnc_pkg::ST_IDLE) || ov_r;
  assign out_valid          = ov_r;
  assign out_cleaned_sample = outd_r;

  // A word is never taken while a result is pending.
  a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input accepted with output pending");
  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_cleaned_sample)))
    else $error("output changed while stalled");
  // The clearing sweep blocks input.
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> in_stall) else $error("input open during clearing sweep");
endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the leaky NLMS noise canceller
// Drives focus and reference word pairs with random idling on both sides,
// predicts every cleaned word with a bit-exact fixed-point model of the
// filter, and compares each output word against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

  localparam int StallLimit = 20000;
  localparam int Latency    = 200;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic signed [15:0] in_focus_sample;
  logic signed [15:0] in_reference_sample;
  logic        out_valid;
  logic        out_stall;
  logic signed [15:0] out_cleaned_sample;

  leaky_nlms_canceller u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_focus_sample     (in_focus_sample),
    .in_reference_sample (in_reference_sample),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_cleaned_sample  (out_cleaned_sample)
  );

  // Shadow copy of the filter state and registers used by the predictor.
  logic [15:0]        step_q;
  logic [12:0]        leak_q;
  logic [15:0]        floor_q;
  logic               enable_q;
  logic               distrac_q;
  logic signed [15:0] hist_q [lnc_pkg::Taps];
  logic signed [31:0] wgt_q  [lnc_pkg::Taps];

  logic signed [15:0] cleaned_fifo [$];
  int  err_count;
  int  idle_cycles;
  bit  quiet;
  bit  hold_long;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Floor division by 2^s, then the half-up rounding built on it.
  function automatic longint floor_div(longint x, int s);
    longint m;
    begin
      if (x >= 0) return x >>> s;
      m = -x;
      return -((m + ((64'sd1 << s) - 1)) >>> s);
    end
  endfunction

  function automatic longint round_div(longint x, int s);
    return floor_div(x + (64'sd1 << (s - 1)), s);
  endfunction

  // Advances the shadow filter by one word pair and returns the cleaned word.
  function automatic logic signed [15:0] cancel_step(logic signed [15:0] focus,
                                                     logic signed [15:0] refs);
    longint acc, norm, est, err, y, g, fa, min_abs, ea, num, q, w, nw;
    logic [63:0] mag;
    begin
      acc = 0; norm = 1024; g = 0;
      for (int i = lnc_pkg::Taps - 1; i > 0; i--) hist_q[i] = hist_q[i - 1];
      hist_q[0] = refs;
      for (int i = 0; i < lnc_pkg::Taps; i++) begin
        acc += longint'(wgt_q[i]) * longint'(hist_q[i]);
        norm += longint'(hist_q[i]) * longint'(hist_q[i]);
      end
      est = round_div(acc, 24);
      err = longint'(focus) - est;
      // The floor only applies to a nonzero focus word; zero error counts
      // as positive.
      if (focus != 0) begin
        fa = (focus < 0) ? -longint'(focus) : longint'(focus);
        min_abs = (longint'(floor_q) * fa + 16384) >>> 15;
        ea = (err < 0) ? -err : err;
        if (ea < min_abs) ea = min_abs;
        err = (err < 0) ? -ea : ea;
      end
      y = (err < -32768) ? -32768 : ((err > 32767) ? 32767 : err);
      if (enable_q && distrac_q) begin
        num = longint'(step_q) * y;
        mag = 64'((num < 0) ? -num : num) << 24;
        q = longint'(mag / 64'(norm));
        g = (num < 0) ? -q : q;
      end
      for (int i = 0; i < lnc_pkg::Taps; i++) begin
        w = wgt_q[i];
        nw = w - round_div(w * longint'(leak_q), 16);
        if (g != 0) nw += round_div(g * longint'(hist_q[i]), 15);
        if (nw > 64'sd2147483647) nw = 64'sd2147483647;
        if (nw < -64'sd2147483648) nw = -64'sd2147483648;
        wgt_q[i] = 32'(nw);
      end
      return 16'(y);
    end
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    begin
      cfg_we <= 1'b1;
      cfg_index <= idx;
      cfg_data <= val;
      @(posedge clk);
      cfg_we <= 1'b0;
      case (idx)
        lnc_pkg::RegStep:    step_q    = val;
        lnc_pkg::RegLeak:    leak_q    = val[12:0];
        lnc_pkg::RegFloor:   floor_q   = val;
        lnc_pkg::RegEnable:  enable_q  = val[0];
        lnc_pkg::RegDistrac: distrac_q = val[0];
        default: ;
      endcase
    end
  endtask

  // Waits until every predicted word has come back, then lets the block settle.
  task automatic drain;
    begin
      while (cleaned_fifo.size() != 0) @(posedge clk);
      repeat (Latency) @(posedge clk);
    end
  endtask

  // Offers one word pair after an idle gap, and holds it until the block
  // takes it. The block is busy right after a word anyway, so the
  // gap of the quiet phase never leaves it waiting.
  task automatic send_pair(logic signed [15:0] focus, logic signed [15:0] refs,
                           logic signed [15:0] known, bit has_known);
    logic signed [15:0] pred;
    begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        @(posedge clk);
      end
      in_valid <= 1'b1;
      in_focus_sample <= focus;
      in_reference_sample <= refs;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      pred = cancel_step(focus, refs);
      if (has_known && pred !== known) begin
        $error("table row: cleaned_sample expected %0d, predicted %0d", known, pred);
        err_count++;
      end
      cleaned_fifo.push_back(pred);
      in_valid <= 1'b0;
    end
  endtask

  // Receiver: random stall bursts, one long hold-off on request, none when quiet.
  initial begin
    out_stall = 1'b1;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (3000) @(posedge clk);
        hold_long = 1'b0;
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Result checker: each accepted word is compared with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (cleaned_fifo.size() == 0) begin
        $error("cleaned_sample %0d arrived with no word expected", out_cleaned_sample);
        err_count++;
      end else begin
        if (out_cleaned_sample !== cleaned_fifo[0]) begin
          $error("cleaned_sample mismatch: expected %0d, actual %0d",
                 cleaned_fifo[0], out_cleaned_sample);
          err_count++;
        end
        void'(cleaned_fifo.pop_front());
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Directed rows: focus, reference, and a typed-in result where obvious.
  typedef struct {
    logic signed [15:0] focus;
    logic signed [15:0] refs;
    logic signed [15:0] known;
    bit                 has_known;
  } pair_row_t;

  pair_row_t pair_table [7] = '{
    '{16'sd0,      16'sd0,      16'sd0,      1'b1}, // zero focus, zero weights
    '{16'sd32767,  16'sd0,      16'sd32767,  1'b1}, // positive extreme
    '{-16'sd32768, 16'sd0,      -16'sd32768, 1'b1}, // negative extreme
    '{16'sd1,      -16'sd32768, 16'sd1,      1'b1},
    '{-16'sd1,     16'sd32767,  -16'sd1,     1'b1},
    '{16'sd12345,  -16'sd4321,  16'sd0,      1'b0},
    '{16'sd0,      16'sd32767,  16'sd0,      1'b0}
  };

  task automatic random_phase(int count, bit quiet_phase);
    logic signed [15:0] f, r;
    begin
      quiet = quiet_phase;
      for (int n = 0; n < count; n++) begin
        case ($urandom_range(0, 5))
          0: f = $urandom_range(0, 1) ? -16'sd32768 : 16'sd32767;
          1: f = 16'sd0;
          2: f = 16'($urandom_range(0, 64)) - 16'sd32;
          default: f = 16'($urandom);
        endcase
        r = ($urandom_range(0, 7) == 0) ? 16'sd0 : 16'($urandom);
        send_pair(f, r, 16'sd0, 1'b0);
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = lnc_pkg::RegStep; cfg_data = 16'd0;
    in_valid = 1'b0; in_focus_sample = 16'sd0; in_reference_sample = 16'sd0;
    err_count = 0; quiet = 1'b0; hold_long = 1'b0;
    step_q = 16'd32768; leak_q = 13'd0; floor_q = 16'd32768;
    enable_q = 1'b0; distrac_q = 1'b0;
    for (int i = 0; i < lnc_pkg::Taps; i++) begin
      hist_q[i] = 16'sd0;
      wgt_q[i] = 32'sd0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (Latency) @(posedge clk);

    // With reset registers and no adaptation the output is the focus word.
    foreach (pair_table[k])
      send_pair(pair_table[k].focus, pair_table[k].refs,
                pair_table[k].known, pair_table[k].has_known);
    drain();

    // Adapting with the default step of 32768, a high floor, and an unknown index.
    write_reg(lnc_pkg::RegEnable, 16'd1);
    write_reg(lnc_pkg::RegDistrac, 16'd1);
    write_reg(3'd7, 16'hFFFF);
    send_pair(16'sd20000, 16'sd30000, 16'sd0, 1'b0);
    send_pair(-16'sd20000, -16'sd32768, 16'sd0, 1'b0);
    send_pair(16'sd100, 16'sd32767, 16'sd0, 1'b0);
    random_phase(150, 1'b0);
    drain();

    // Smallest step, no leak, lowest floor; long receiver hold-off inside.
    write_reg(lnc_pkg::RegStep, 16'd33);
    write_reg(lnc_pkg::RegLeak, 16'd0);
    write_reg(lnc_pkg::RegFloor, 16'd2065);
    hold_long = 1'b1;
    random_phase(200, 1'b0);
    drain();

    // Largest leak, registers above range, no floor.
    write_reg(lnc_pkg::RegStep, 16'hFFFF);
    write_reg(lnc_pkg::RegLeak, 16'h1FFF);
    write_reg(lnc_pkg::RegFloor, 16'd0);
    random_phase(150, 1'b0);
    drain();

    // Mid step and leak, highest floor; distractor absent so weights only leak.
    write_reg(lnc_pkg::RegStep, 16'd8000);
    write_reg(lnc_pkg::RegLeak, 16'd6554);
    write_reg(lnc_pkg::RegFloor, 16'hFFFF);
    write_reg(lnc_pkg::RegDistrac, 16'd0);
    random_phase(100, 1'b0);
    drain();

    // Adaptation back on with random legal settings, then a quiet finish.
    write_reg(lnc_pkg::RegStep, 16'($urandom_range(33, 32768)));
    write_reg(lnc_pkg::RegLeak, 16'($urandom_range(0, 300)));
    write_reg(lnc_pkg::RegFloor, 16'($urandom_range(2065, 32768)));
    write_reg(lnc_pkg::RegDistrac, 16'd1);
    random_phase(200, 1'b0);
    random_phase(150, 1'b1);

    drain();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/lnc_pkg.sv
rtl/core/lnc_ram.sv
rtl/core/lnc_div.sv
rtl/core/leaky_nlms_canceller.sv
tb/sv/testbench.sv
